// File: hw/rtl/ebpc_pkg.sv
// Shared types and constants for the elastic ball pair collision block.
package ebpc_pkg;

  localparam int MID_DEPTH_DEF = 4;   // front-to-back queue depth
  localparam int OUT_DEPTH_DEF = 4;   // result queue depth
  localparam int QX_W          = 48;  // quotient bits of the line projection divide
  localparam int GQ_W          = 26;  // quotient bits of the mass ratio divide
  localparam int FRONT_STAGES  = 6;

  typedef struct packed {
    logic [31:0] pos_a_x;
    logic [31:0] pos_a_y;
    logic [31:0] vel_a_x;
    logic [31:0] vel_a_y;
    logic [30:0] radius_a;
    logic [30:0] mass_a;
    logic [31:0] pos_b_x;
    logic [31:0] pos_b_y;
    logic [31:0] vel_b_x;
    logic [31:0] vel_b_y;
    logic [30:0] radius_b;
    logic [30:0] mass_b;
  } in_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
  } vel4_t;

  typedef struct packed {
    logic hit;
    logic ovl;
    logic deg;
  } flags_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        rs;
    vel4_t              v;
    logic [30:0]        ma;
    logic [30:0]        mb;
  } f1_t;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic        sx;
    logic        sy;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] rs2;
    logic        ltx;
    logic        lty;
    logic        deg;
    logic [4:0]  k;
    vel4_t       v;
    logic [30:0] ma;
    logic [30:0] mb;
  } f2_t;

  typedef struct packed {
    logic               ovl;
    logic               deg;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    vel4_t              v;
    logic [30:0]        ma;
    logic [30:0]        mb;
  } f3_t;

  typedef struct packed {
    logic signed [47:0] pax;
    logic signed [47:0] pay;
    logic signed [47:0] pbx;
    logic signed [47:0] pby;
    logic [29:0]        uxx;
    logic [29:0]        uyy;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic               ovl;
    logic               deg;
    vel4_t              v;
    logic [30:0]        ma;
    logic [30:0]        mb;
  } f4_t;

  typedef struct packed {
    logic signed [47:0] sa;
    logic signed [47:0] sb;
    logic [30:0]        q;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic               ovl;
    logic               deg;
    vel4_t              v;
    logic [30:0]        ma;
    logic [30:0]        mb;
  } f5_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic signed [48:0] p;
    logic [30:0]        q;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    vel4_t              v;
    logic [30:0]        ma;
    logic [30:0]        mb;
    flags_t             fl;
  } mid_t;

  typedef struct packed {
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic [31:0]        msum;
    logic [30:0]        q;
    logic [30:0]        ma;
    logic [30:0]        mb;
    vel4_t              v;
    flags_t             fl;
  } b0_t;

  // Divider stage: remainder on top, dividend bits shifting out, quotient bits in.
  typedef struct packed {
    logic [78:0] wx;
    logic [78:0] wy;
    logic        nx;
    logic        ny;
    logic [30:0] q;
    logic [57:0] wa;
    logic [57:0] wb;
    logic [31:0] msum;
    logic        gz;
    vel4_t       v;
    flags_t      fl;
  } div_t;

  typedef struct packed {
    logic [3:0][49:0] hi;
    logic [3:0][49:0] lo;
    logic             nx;
    logic             ny;
    vel4_t            v;
    flags_t           fl;
  } sc1_t;

  typedef struct packed {
    logic [3:0][50:0] s;
    logic             nx;
    logic             ny;
    vel4_t            v;
    flags_t           fl;
  } sc2_t;

  typedef struct packed {
    logic [31:0] new_vel_a_x;
    logic [31:0] new_vel_a_y;
    logic [31:0] new_vel_b_x;
    logic [31:0] new_vel_b_y;
    logic        collided;
    logic        overlapping;
    logic        degenerate;
  } res_t;

endpackage

// File: hw/rtl/ebpc_fifo.sv
// Small register queue used between front and back and at the result side.
module ebpc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ebpc_front.sv
// Front pipeline: overlap test, line direction, projections and collision decision.
module ebpc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_push,
  input  ebpc_pkg::in_t  in_item,
  output logic           in_full,
  output logic           mid_push,
  output ebpc_pkg::mid_t mid_item,
  input  logic           mid_full
);

  import ebpc_pkg::*;

  // shift so the larger offset magnitude fits 15 bits
  function automatic logic [4:0] norm_shift(input logic [32:0] m);
    logic [4:0] k;
    k = '0;
    for (int i = 15; i < 33; i++) begin
      if (m[i]) k = 5'(i - 14);
    end
    return k;
  endfunction

  logic                    en;
  logic [FRONT_STAGES-1:0] vld;
  f1_t  s1, s1_next;
  f2_t  s2, s2_next;
  f3_t  s3, s3_next;
  f4_t  s4, s4_next;
  f5_t  s5, s5_next;
  mid_t s6, s6_next;
  logic [32:0] negx, negy;
  logic [32:0] shx, shy;

  assign en       = !(vld[FRONT_STAGES-1] && mid_full);
  assign in_full  = !en || rst;
  assign mid_push = en && vld[FRONT_STAGES-1];
  assign mid_item = s6;

  always_comb begin
    s1_next.dx = $signed({in_item.pos_a_x[31], in_item.pos_a_x})
               - $signed({in_item.pos_b_x[31], in_item.pos_b_x});
    s1_next.dy = $signed({in_item.pos_a_y[31], in_item.pos_a_y})
               - $signed({in_item.pos_b_y[31], in_item.pos_b_y});
    s1_next.rs = {1'b0, in_item.radius_a} + {1'b0, in_item.radius_b};
    s1_next.v  = '{ax: in_item.vel_a_x, ay: in_item.vel_a_y,
                   bx: in_item.vel_b_x, by: in_item.vel_b_y};
    s1_next.ma = in_item.mass_a;
    s1_next.mb = in_item.mass_b;
  end

  always_comb begin
    negx = -s1.dx;
    negy = -s1.dy;
    s2_next.sx  = s1.dx[32];
    s2_next.sy  = s1.dy[32];
    s2_next.ax  = s1.dx[32] ? negx : s1.dx;
    s2_next.ay  = s1.dy[32] ? negy : s1.dy;
    s2_next.a   = 64'(s2_next.ax[31:0]) * 64'(s2_next.ax[31:0]);
    s2_next.b   = 64'(s2_next.ay[31:0]) * 64'(s2_next.ay[31:0]);
    s2_next.rs2 = 64'(s1.rs) * 64'(s1.rs);
    s2_next.ltx = s2_next.ax < {1'b0, s1.rs};
    s2_next.lty = s2_next.ay < {1'b0, s1.rs};
    s2_next.deg = (s1.dx == '0) && (s1.dy == '0);
    s2_next.k   = norm_shift(s2_next.ax | s2_next.ay);
    s2_next.v   = s1.v;
    s2_next.ma  = s1.ma;
    s2_next.mb  = s1.mb;
  end

  always_comb begin
    shx = s2.ax >> s2.k;
    shy = s2.ay >> s2.k;
    s3_next.ovl = s2.ltx && s2.lty
               && (({1'b0, s2.a} + {1'b0, s2.b}) < {1'b0, s2.rs2});
    s3_next.deg = s2.deg;
    s3_next.ux  = s2.sx ? -$signed({1'b0, shx[14:0]}) : $signed({1'b0, shx[14:0]});
    s3_next.uy  = s2.sy ? -$signed({1'b0, shy[14:0]}) : $signed({1'b0, shy[14:0]});
    s3_next.v   = s2.v;
    s3_next.ma  = s2.ma;
    s3_next.mb  = s2.mb;
  end

  always_comb begin
    s4_next.pax = 48'($signed(s3.v.ax) * s3.ux);
    s4_next.pay = 48'($signed(s3.v.ay) * s3.uy);
    s4_next.pbx = 48'($signed(s3.v.bx) * s3.ux);
    s4_next.pby = 48'($signed(s3.v.by) * s3.uy);
    s4_next.uxx = 30'(s3.ux * s3.ux);
    s4_next.uyy = 30'(s3.uy * s3.uy);
    s4_next.ux  = s3.ux;
    s4_next.uy  = s3.uy;
    s4_next.ovl = s3.ovl;
    s4_next.deg = s3.deg;
    s4_next.v   = s3.v;
    s4_next.ma  = s3.ma;
    s4_next.mb  = s3.mb;
  end

  always_comb begin
    s5_next.sa  = s4.pax + s4.pay;
    s5_next.sb  = s4.pbx + s4.pby;
    s5_next.q   = 31'(s4.uxx) + 31'(s4.uyy);
    s5_next.ux  = s4.ux;
    s5_next.uy  = s4.uy;
    s5_next.ovl = s4.ovl;
    s5_next.deg = s4.deg;
    s5_next.v   = s4.v;
    s5_next.ma  = s4.ma;
    s5_next.mb  = s4.mb;
  end

  always_comb begin
    s6_next.p      = 49'(s5.sb) - 49'(s5.sa);
    s6_next.q      = s5.q;
    s6_next.ux     = s5.ux;
    s6_next.uy     = s5.uy;
    s6_next.v      = s5.v;
    s6_next.ma     = s5.ma;
    s6_next.mb     = s5.mb;
    s6_next.fl.ovl = s5.ovl;
    s6_next.fl.deg = s5.deg;
    // separating pair: B moving away and A moving away along the line
    s6_next.fl.hit = s5.ovl && !s5.deg
                  && !(s5.sb[47] && !s5.sa[47] && (s5.sa != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

endmodule

// File: hw/rtl/ebpc_back.sv
// Back pipeline: projection and mass ratio divides, scaling and saturation.
module ebpc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_valid,
  input  ebpc_pkg::mid_t mid_item,
  output logic           mid_pop,
  output logic           out_push,
  output ebpc_pkg::res_t out_item,
  input  logic           out_full
);

  import ebpc_pkg::*;

  localparam int TOP = QX_W + 4;  // b0, QX_W+1 divider regs, three scale regs

  function automatic logic [78:0] qstep(input logic [78:0] w, input logic [30:0] d);
    logic [31:0] t;
    logic [31:0] diff;
    t    = {w[78:48], w[47]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) return {diff[30:0], w[46:0], 1'b1};
    else                return {t[30:0], w[46:0], 1'b0};
  endfunction

  function automatic logic [57:0] gstep(input logic [57:0] w, input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {w[57:26], w[25]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) return {diff[31:0], w[24:0], 1'b1};
    else                return {t[31:0], w[24:0], 1'b0};
  endfunction

  function automatic logic [31:0] apply(input logic [31:0] v, input logic [50:0] s,
                                        input logic neg);
    logic signed [53:0] sv;
    logic signed [53:0] acc;
    sv  = neg ? -$signed({3'b0, s}) : $signed({3'b0, s});
    acc = $signed({{22{v[31]}}, v}) + sv;
    if (acc > 54'sd2147483647)       return 32'h7fff_ffff;
    else if (acc < -54'sd2147483648) return 32'h8000_0000;
    else                             return acc[31:0];
  endfunction

  logic         en;
  logic [TOP:0] vld;
  b0_t  b0, b0_next;
  div_t dv [QX_W+1];
  div_t dv0_next;
  sc1_t c1, c1_next;
  sc2_t c2, c2_next;
  res_t c3, c3_next;
  logic [63:0] negpx, negpy;
  logic [62:0] magx, magy;
  logic [25:0] ga, gb;

  assign en       = !(vld[TOP] && out_full);
  assign mid_pop  = en && mid_valid;
  assign out_push = en && vld[TOP];
  assign out_item = c3;

  always_comb begin
    b0_next.px   = 64'(mid_item.p * mid_item.ux);
    b0_next.py   = 64'(mid_item.p * mid_item.uy);
    b0_next.msum = {1'b0, mid_item.ma} + {1'b0, mid_item.mb};
    b0_next.q    = mid_item.q;
    b0_next.ma   = mid_item.ma;
    b0_next.mb   = mid_item.mb;
    b0_next.v    = mid_item.v;
    b0_next.fl   = mid_item.fl;
  end

  always_comb begin
    negpx = -b0.px;
    negpy = -b0.py;
    magx  = b0.px[63] ? negpx[62:0] : b0.px[62:0];
    magy  = b0.py[63] ? negpy[62:0] : b0.py[62:0];
    dv0_next.wx   = {16'b0, magx};
    dv0_next.wy   = {16'b0, magy};
    dv0_next.nx   = b0.px[63];
    dv0_next.ny   = b0.py[63];
    dv0_next.q    = b0.q;
    dv0_next.wa   = {2'b0, b0.ma, 25'b0};
    dv0_next.wb   = {2'b0, b0.mb, 25'b0};
    dv0_next.msum = b0.msum;
    dv0_next.gz   = (b0.msum == '0);
    dv0_next.v    = b0.v;
    dv0_next.fl   = b0.fl;
  end

  for (genvar i = 0; i < QX_W; i++) begin : g_div
    div_t nxt;
    always_comb begin
      nxt    = dv[i];
      nxt.wx = qstep(dv[i].wx, dv[i].q);
      nxt.wy = qstep(dv[i].wy, dv[i].q);
      if (i < GQ_W) begin
        nxt.wa = gstep(dv[i].wa, dv[i].msum);
        nxt.wb = gstep(dv[i].wb, dv[i].msum);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    ga = dv[QX_W].gz ? '0 : dv[QX_W].wa[25:0];
    gb = dv[QX_W].gz ? '0 : dv[QX_W].wb[25:0];
    // A gets the B mass ratio, B gets the A mass ratio
    c1_next.hi[0] = 50'(dv[QX_W].wx[47:24]) * 50'(gb);
    c1_next.lo[0] = 50'(dv[QX_W].wx[23:0])  * 50'(gb);
    c1_next.hi[1] = 50'(dv[QX_W].wy[47:24]) * 50'(gb);
    c1_next.lo[1] = 50'(dv[QX_W].wy[23:0])  * 50'(gb);
    c1_next.hi[2] = 50'(dv[QX_W].wx[47:24]) * 50'(ga);
    c1_next.lo[2] = 50'(dv[QX_W].wx[23:0])  * 50'(ga);
    c1_next.hi[3] = 50'(dv[QX_W].wy[47:24]) * 50'(ga);
    c1_next.lo[3] = 50'(dv[QX_W].wy[23:0])  * 50'(ga);
    c1_next.nx    = dv[QX_W].nx;
    c1_next.ny    = dv[QX_W].ny;
    c1_next.v     = dv[QX_W].v;
    c1_next.fl    = dv[QX_W].fl;
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      // round half up on the low partial product, then drop 24 fraction bits
      c2_next.s[j] = 51'(c1.hi[j]) + ((51'(c1.lo[j]) + 51'(24'h80_0000)) >> 24);
    end
    c2_next.nx = c1.nx;
    c2_next.ny = c1.ny;
    c2_next.v  = c1.v;
    c2_next.fl = c1.fl;
  end

  always_comb begin
    if (c2.fl.hit) begin
      c3_next.new_vel_a_x = apply(c2.v.ax, c2.s[0], c2.nx);
      c3_next.new_vel_a_y = apply(c2.v.ay, c2.s[1], c2.ny);
      c3_next.new_vel_b_x = apply(c2.v.bx, c2.s[2], !c2.nx);
      c3_next.new_vel_b_y = apply(c2.v.by, c2.s[3], !c2.ny);
    end else begin
      c3_next.new_vel_a_x = c2.v.ax;
      c3_next.new_vel_a_y = c2.v.ay;
      c3_next.new_vel_b_x = c2.v.bx;
      c3_next.new_vel_b_y = c2.v.by;
    end
    c3_next.collided    = c2.fl.hit;
    c3_next.overlapping = c2.fl.ovl;
    c3_next.degenerate  = c2.fl.deg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOP-1:0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0    <= b0_next;
      dv[0] <= dv0_next;
      c1    <= c1_next;
      c2    <= c2_next;
      c3    <= c3_next;
    end
  end

endmodule

// File: hw/rtl/elastic_ball_pair_collision.sv
// Top level of the elastic ball pair collision block.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  input    | push / full      | positions, velocities, radii, masses of A and B
//  result   | pop / empty      | new velocities, collided, overlapping, degenerate
//
// One transaction per cycle sustained unless a full queue freezes a pipeline; every stage is pipelined.
// With no stalls a transaction passes the 6 front stages, the middle queue, the 53 back
// stages (48 of them the bit-per-stage projection divide) and the result queue.
// Synchronous active-high reset empties both queues, clears all stage valids and
// holds full high.
// Front and back each freeze only while their last stage holds a transaction and
// the queue after it is full; full on the input follows the front's freeze.
module elastic_ball_pair_collision #(
  parameter int MID_DEPTH = ebpc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = ebpc_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] pos_a_x,
  input  logic [31:0] pos_a_y,
  input  logic [31:0] vel_a_x,
  input  logic [31:0] vel_a_y,
  input  logic [30:0] radius_a,
  input  logic [30:0] mass_a,
  input  logic [31:0] pos_b_x,
  input  logic [31:0] pos_b_y,
  input  logic [31:0] vel_b_x,
  input  logic [31:0] vel_b_y,
  input  logic [30:0] radius_b,
  input  logic [30:0] mass_b,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] new_vel_a_x,
  output logic [31:0] new_vel_a_y,
  output logic [31:0] new_vel_b_x,
  output logic [31:0] new_vel_b_y,
  output logic        collided,
  output logic        overlapping,
  output logic        degenerate
);

  import ebpc_pkg::*;

  in_t  in_item;
  mid_t mid_wr, mid_rd;
  res_t out_wr, out_rd;
  logic mid_push, mid_full, mid_pop, mid_empty;
  logic out_push, out_full;

  assign in_item = '{pos_a_x: pos_a_x, pos_a_y: pos_a_y, vel_a_x: vel_a_x,
                     vel_a_y: vel_a_y, radius_a: radius_a, mass_a: mass_a,
                     pos_b_x: pos_b_x, pos_b_y: pos_b_y, vel_b_x: vel_b_x,
                     vel_b_y: vel_b_y, radius_b: radius_b, mass_b: mass_b};

  // front: distance test, unit line, projections, separating-pair check
  ebpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push),
    .in_item  (in_item),
    .in_full  (full),
    .mid_push (mid_push),
    .mid_item (mid_wr),
    .mid_full (mid_full)
  );

  // decouples the short front from the long divide pipeline
  ebpc_fifo #(
    .W     ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  // back: divides, mass-ratio scaling, saturation
  ebpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (!mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .out_item  (out_wr),
    .out_full  (out_full)
  );

  // result queue; its head drives the result ports
  ebpc_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wr),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rd),
    .empty (empty)
  );

  assign new_vel_a_x = out_rd.new_vel_a_x;
  assign new_vel_a_y = out_rd.new_vel_a_y;
  assign new_vel_b_x = out_rd.new_vel_b_x;
  assign new_vel_b_y = out_rd.new_vel_b_y;
  assign collided    = out_rd.collided;
  assign overlapping = out_rd.overlapping;
  assign degenerate  = out_rd.degenerate;

  // front never pushes into a full middle queue
  a_mid_room: assert property (@(posedge clk) disable iff (rst) mid_push |-> !mid_full)
    else $error("front pushed into full middle queue");

  // back never pushes into a full result queue
  a_out_room: assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("back pushed into full result queue");

  // a collision needs overlap and a defined line
  a_hit_flags: assert property (@(posedge clk) disable iff (rst)
    (!empty && collided) |-> (overlapping && !degenerate))
    else $error("collided without overlap or with coincident centers");

endmodule
